>>> hdl/skct_pkg.sv
// ----------------------------------------------------------------------------
// skct_pkg: shared types and constants for the sorted key count table
// Table geometry, request codes, sequencer states and the record that
// each cell hands to the readout tree.
// ----------------------------------------------------------------------------
package skct_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 152;
    localparam int KEY_HI_W    = 64;
    localparam int KEY_MID_W   = 64;
    localparam int KEY_LO_W    = 24;
    localparam int CNT_W       = 32;
    localparam int POS_W       = 8;
    localparam int DK_W        = 9;
    localparam int CMP_W       = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int GRP_SIZE    = 16;
    localparam int GRP_CNT     = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int SLOT_CNT    = GRP_CNT * GRP_SIZE;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        REQ_COUNT = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL,
        ST_RED
    } t_state;

    // Record a selected cell places on the readout tree; zero when not selected
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
        logic [KEY_W-1:0] key;
    } t_rec;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             upd_en;
        logic             is_read;
        logic             ins;
        logic [POS_W-1:0] rd_idx;
    } t_cell_ctl;

endpackage

>>> hdl/skct_cell.sv
// ----------------------------------------------------------------------------
// skct_cell: one table slot
// Holds a key and its count, compares against the broadcast key, and on an
// insert either loads the new key, takes its lower neighbor's entry, or holds.
// ----------------------------------------------------------------------------
module skct_cell
    import skct_pkg::*;
(
    input  logic              i_clk,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [USED_W-1:0] i_used,
    input  logic [KEY_W-1:0]  i_key,
    input  t_cell_ctl         i_ctl,
    input  logic              i_prev_lt,
    input  logic [KEY_W-1:0]  i_prev_key,
    input  logic [CNT_W-1:0]  i_prev_cnt,
    output logic              o_lt,
    output logic              o_eq,
    output logic [KEY_W-1:0]  o_key,
    output logic [CNT_W-1:0]  o_cnt,
    output t_rec              o_rec
);

    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_cnt;
    logic             r_lt;
    logic             r_eq;
    logic             w_occ;
    logic             w_sel;

    assign w_occ = USED_W'(i_index) < i_used;

    // Count mode: the first slot whose key is not below the request key
    assign w_sel = i_ctl.is_read
                 ? (w_occ && (CMP_W'(i_index) == CMP_W'(i_ctl.rd_idx)))
                 : (i_prev_lt && !r_lt);

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_lt <= w_occ && (r_key < i_key);
            r_eq <= w_occ && (r_key == i_key);
        end
        if (i_ctl.upd_en) begin
            if (r_eq) begin
                if (r_cnt != COUNT_MAX) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else if (i_ctl.ins) begin
                if (w_sel) begin
                    r_key <= i_key;
                    r_cnt <= CNT_W'(1);
                end else if (!r_lt) begin
                    // shift up: take the entry below
                    r_key <= i_prev_key;
                    r_cnt <= i_prev_cnt;
                end
            end
        end
    end

    assign o_lt  = r_lt;
    assign o_eq  = r_eq;
    assign o_key = r_key;
    assign o_cnt = r_cnt;

    always_comb begin
        o_rec = '0;
        if (w_sel) begin
            o_rec.hit = 1'b1;
            o_rec.pos = POS_W'(i_index);
            o_rec.cnt = r_cnt;
            o_rec.key = r_key;
        end
    end

endmodule

>>> hdl/skct_group_or.sv
// ----------------------------------------------------------------------------
// skct_group_or: first level of the readout tree
// Merges the records of one group of cells and registers the result.
// At most one cell in the whole table is selected.
// ----------------------------------------------------------------------------
module skct_group_or
    import skct_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_rec i_rec [GRP_SIZE],
    output t_rec o_rec
);

    t_rec r_rec;
    t_rec n_rec;

    always_comb begin
        n_rec = '0;
        for (int k = 0; k < GRP_SIZE; k++) begin
            n_rec = n_rec | i_rec[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rec <= n_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

>>> hdl/sorted_key_count_table.sv
// Each accepted request passes through accept, compare, select/shift with
// group merge, and final merge through the two-level readout tree into the
// output register; a new request is taken only after the last one is done.
// A result waiting on a stalled output holds the final merge, not the input.
// Reset (i_rst_n low, synchronous) empties the table at once and clears the
// sequencer and output valid; slot contents are left as they are.
// ----------------------------------------------------------------------------
// sorted_key_count_table: sorted key table with occurrence counts
// A row of cells keeps distinct keys in ascending order. Count requests
// increment a matching entry or, with room left, insert the key at its sorted
// place, read requests return one entry, clear requests empty the table.
// ----------------------------------------------------------------------------
module sorted_key_count_table
    import skct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_req_type,
    input  logic [KEY_HI_W-1:0]  i_key_hi,
    input  logic [KEY_MID_W-1:0] i_key_mid,
    input  logic [KEY_LO_W-1:0]  i_key_lo,
    input  logic [POS_W-1:0]     i_read_index,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [POS_W-1:0]     o_position,
    output logic                 o_was_new,
    output logic [CNT_W-1:0]     o_occurrences,
    output logic [DK_W-1:0]      o_distinct_keys,
    output logic                 o_table_full,
    output logic [KEY_HI_W-1:0]  o_out_key_hi,
    output logic [KEY_MID_W-1:0] o_out_key_mid,
    output logic [KEY_LO_W-1:0]  o_out_key_lo
);

    t_state r_state;
    t_state n_state;

    logic [1:0]        r_req;
    logic [KEY_W-1:0]  r_key;
    logic [POS_W-1:0]  r_idx;
    logic [USED_W-1:0] r_used;
    logic              r_found;
    logic              r_full;

    logic              r_out_valid;
    logic [POS_W-1:0]  r_position;
    logic              r_was_new;
    logic [CNT_W-1:0]  r_occurrences;
    logic [DK_W-1:0]   r_distinct_keys;
    logic              r_table_full;
    logic [KEY_W-1:0]  r_out_key;

    logic              w_accept;
    logic              w_is_count;
    logic              w_found;
    logic              w_full;
    logic              w_load_out;
    logic              w_grp_en;
    t_cell_ctl         w_ctl;
    t_rec              w_final;

    logic              w_lt  [TABLE_DEPTH];
    logic              w_eq  [TABLE_DEPTH];
    logic [KEY_W-1:0]  w_key [TABLE_DEPTH];
    logic [CNT_W-1:0]  w_cnt [TABLE_DEPTH];
    t_rec              w_rec [SLOT_CNT];
    t_rec              w_grp [GRP_CNT];

    assign w_accept   = i_valid && !o_stall;
    assign w_is_count = (r_req == REQ_COUNT);
    assign w_full     = (r_used == USED_W'(TABLE_DEPTH));

    always_comb begin
        w_found = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_found = w_found | w_eq[k];
        end
    end

    // Sequencer: next state and broadcast control
    always_comb begin
        n_state      = r_state;
        o_stall      = 1'b1;
        w_load_out   = 1'b0;
        w_grp_en     = 1'b0;
        w_ctl        = '0;
        w_ctl.is_read = (r_req == REQ_READ);
        w_ctl.ins    = !w_found && !w_full;
        w_ctl.rd_idx = r_idx;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                w_ctl.cmp_en = 1'b1;
                n_state      = ST_SEL;
            end
            ST_SEL: begin
                w_ctl.upd_en = w_is_count;
                w_grp_en     = 1'b1;
                n_state      = ST_RED;
            end
            ST_RED: begin
                if (!r_out_valid || !i_stall) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req_type;
            r_key <= {i_key_hi, i_key_mid, i_key_lo};
            r_idx <= i_read_index;
        end
    end

    // Fill count and per-request outcome
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (r_state == ST_SEL) begin
            if (r_req == REQ_CLEAR) begin
                r_used <= '0;
            end else if (w_is_count && w_ctl.ins) begin
                r_used <= r_used + USED_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEL) begin
            r_found <= w_found;
            r_full  <= w_full;
        end
    end

    // Cell row
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        logic             w_prev_lt;
        logic [KEY_W-1:0] w_prev_key;
        logic [CNT_W-1:0] w_prev_cnt;

        if (gi == 0) begin : g_first
            assign w_prev_lt  = 1'b1;
            assign w_prev_key = '0;
            assign w_prev_cnt = '0;
        end else begin : g_rest
            assign w_prev_lt  = w_lt[gi-1];
            assign w_prev_key = w_key[gi-1];
            assign w_prev_cnt = w_cnt[gi-1];
        end

        skct_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (IDX_W'(gi)),
            .i_used     (r_used),
            .i_key      (r_key),
            .i_ctl      (w_ctl),
            .i_prev_lt  (w_prev_lt),
            .i_prev_key (w_prev_key),
            .i_prev_cnt (w_prev_cnt),
            .o_lt       (w_lt[gi]),
            .o_eq       (w_eq[gi]),
            .o_key      (w_key[gi]),
            .o_cnt      (w_cnt[gi]),
            .o_rec      (w_rec[gi])
        );
    end

    for (genvar gp = TABLE_DEPTH; gp < SLOT_CNT; gp++) begin : g_pad
        assign w_rec[gp] = '0;
    end

    // Readout tree
    for (genvar gg = 0; gg < GRP_CNT; gg++) begin : g_grp
        skct_group_or u_grp (
            .i_clk (i_clk),
            .i_en  (w_grp_en),
            .i_rec (w_rec[gg*GRP_SIZE +: GRP_SIZE]),
            .o_rec (w_grp[gg])
        );
    end

    always_comb begin
        w_final = '0;
        for (int k = 0; k < GRP_CNT; k++) begin
            w_final = w_final | w_grp[k];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_position      <= '0;
            r_was_new       <= 1'b0;
            r_occurrences   <= '0;
            r_table_full    <= 1'b0;
            r_out_key       <= '0;
            r_distinct_keys <= DK_W'(r_used);
            case (r_req)
                REQ_COUNT: begin
                    r_out_key <= r_key;
                    if (r_found) begin
                        r_position    <= w_final.pos;
                        r_occurrences <= (w_final.cnt == COUNT_MAX)
                                       ? COUNT_MAX : w_final.cnt + CNT_W'(1);
                    end else if (r_full) begin
                        r_table_full <= 1'b1;
                    end else begin
                        r_position    <= w_final.pos;
                        r_was_new     <= 1'b1;
                        r_occurrences <= CNT_W'(1);
                    end
                end
                REQ_READ: begin
                    r_position <= r_idx;
                    if (w_final.hit) begin
                        r_occurrences <= w_final.cnt;
                        r_out_key     <= w_final.key;
                    end
                end
                default: begin
                    // clear and unknown requests report only the fill count
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_position      = r_position;
    assign o_was_new       = r_was_new;
    assign o_occurrences   = r_occurrences;
    assign o_distinct_keys = r_distinct_keys;
    assign o_table_full    = r_table_full;
    assign o_out_key_hi    = r_out_key[KEY_W-1 -: KEY_HI_W];
    assign o_out_key_mid   = r_out_key[KEY_LO_W +: KEY_MID_W];
    assign o_out_key_lo    = r_out_key[KEY_LO_W-1:0];

endmodule

>>> hdl/skct_checker.sv
// ----------------------------------------------------------------------------
// skct_checker: port-level checks for the sorted key count table
// Watches the request and result channels only.
// ----------------------------------------------------------------------------
module skct_checker
    import skct_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [POS_W-1:0]     o_position,
    input logic                 o_was_new,
    input logic [CNT_W-1:0]     o_occurrences,
    input logic [DK_W-1:0]      o_distinct_keys,
    input logic                 o_table_full
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_occurrences)
                                  && $stable(o_position)))
        else $error("stalled result changed");

    // an accepted request blocks the next one while it is worked on
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted while busy");

    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_new) |->
            (o_occurrences == CNT_W'(1) && !o_table_full && o_distinct_keys != '0))
        else $error("inserted entry reports bad count");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |->
            (o_distinct_keys == DK_W'(TABLE_DEPTH) && !o_was_new
             && o_occurrences == '0))
        else $error("drop reported with room left");

endmodule

bind sorted_key_count_table skct_checker u_skct_checker (.*);

>>> dv/tb_sorted_key_count_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_count_table: self-checking bench for the sorted key count table
// Drives count, read, clear and unknown requests with random pacing on both
// sides, tracks the table in a shadow copy and checks every response field.
// ----------------------------------------------------------------------------
module tb_sorted_key_count_table;
    import skct_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]     position;
        logic                 was_new;
        logic [CNT_W-1:0]     occurrences;
        logic [DK_W-1:0]      distinct_keys;
        logic                 table_full;
        logic [KEY_HI_W-1:0]  key_hi;
        logic [KEY_MID_W-1:0] key_mid;
        logic [KEY_LO_W-1:0]  key_lo;
    } t_lookup;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    logic [1:0]           req_type;
    logic [KEY_HI_W-1:0]  req_key_hi;
    logic [KEY_MID_W-1:0] req_key_mid;
    logic [KEY_LO_W-1:0]  req_key_lo;
    logic [POS_W-1:0]     req_read_index;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [POS_W-1:0]     rsp_position;
    logic                 rsp_was_new;
    logic [CNT_W-1:0]     rsp_occurrences;
    logic [DK_W-1:0]      rsp_distinct_keys;
    logic                 rsp_table_full;
    logic [KEY_HI_W-1:0]  rsp_key_hi;
    logic [KEY_MID_W-1:0] rsp_key_mid;
    logic [KEY_LO_W-1:0]  rsp_key_lo;

    // shadow copy of the table
    logic [KEY_W-1:0] shadow_key [TABLE_DEPTH];
    logic [CNT_W-1:0] shadow_cnt [TABLE_DEPTH];
    int               shadow_used = 0;

    t_lookup          lookup_queue[$];
    logic [KEY_W-1:0] key_pool[$];

    bit send_gaps_on   = 1'b1;
    bit recv_stalls_on = 1'b1;
    int stall_left     = 0;

    int sent_cnt = 0, new_keys = 0, repeat_hits = 0, dropped_keys = 0;
    int reads_done = 0, clears_done = 0, results_seen = 0, mismatch_cnt = 0;

    sorted_key_count_table i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_req_type      (req_type),
        .i_key_hi        (req_key_hi),
        .i_key_mid       (req_key_mid),
        .i_key_lo        (req_key_lo),
        .i_read_index    (req_read_index),
        .o_valid         (rsp_valid),
        .i_stall         (rsp_stall),
        .o_position      (rsp_position),
        .o_was_new       (rsp_was_new),
        .o_occurrences   (rsp_occurrences),
        .o_distinct_keys (rsp_distinct_keys),
        .o_table_full    (rsp_table_full),
        .o_out_key_hi    (rsp_key_hi),
        .o_out_key_mid   (rsp_key_mid),
        .o_out_key_lo    (rsp_key_lo)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the shadow table and return the response it owes
    function automatic t_lookup shadow_lookup(logic [1:0] req, logic [KEY_W-1:0] k,
                                              logic [POS_W-1:0] idx);
        t_lookup r;
        int      at;
        r = '0;
        case (req)
            REQ_COUNT: begin
                at = 0;
                while (at < shadow_used && shadow_key[at] < k) at++;
                if (at < shadow_used && shadow_key[at] == k) begin
                    if (shadow_cnt[at] != COUNT_MAX) shadow_cnt[at] = shadow_cnt[at] + 1;
                    r.position    = at[POS_W-1:0];
                    r.occurrences = shadow_cnt[at];
                end else if (shadow_used >= TABLE_DEPTH) begin
                    r.table_full = 1'b1;
                end else begin
                    for (int j = shadow_used; j > at; j--) begin
                        shadow_key[j] = shadow_key[j-1];
                        shadow_cnt[j] = shadow_cnt[j-1];
                    end
                    shadow_key[at] = k;
                    shadow_cnt[at] = 1;
                    shadow_used++;
                    r.position    = at[POS_W-1:0];
                    r.was_new     = 1'b1;
                    r.occurrences = 1;
                end
                {r.key_hi, r.key_mid, r.key_lo} = k;
            end
            REQ_READ: begin
                r.position = idx;
                if (idx < shadow_used) begin
                    r.occurrences = shadow_cnt[idx];
                    {r.key_hi, r.key_mid, r.key_lo} = shadow_key[idx];
                end
            end
            REQ_CLEAR: shadow_used = 0;
            default: ;
        endcase
        r.distinct_keys = shadow_used[DK_W-1:0];
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] rand_name();
        logic [KEY_W-1:0] k;
        int               len;
        k   = '0;
        len = $urandom_range(1, 19);
        for (int b = 0; b < len; b++)
            k[KEY_W-1-8*b -: 8] = 8'($urandom_range(8'h61, 8'h7a));
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] rand_raw();
        return KEY_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    endfunction

    function automatic logic [KEY_W-1:0] pick_count_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 8) return rand_name();
        return rand_raw();
    endfunction

    function automatic logic [POS_W-1:0] pick_read_index();
        if (shadow_used > 0 && $urandom_range(0, 4) != 0)
            return POS_W'($urandom_range(0, shadow_used - 1));
        return POS_W'($urandom_range(0, 255));
    endfunction

    function automatic void shuffle_pacing();
        send_gaps_on   = ($urandom_range(0, 3) != 0);
        recv_stalls_on = ($urandom_range(0, 3) != 0);
    endfunction

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    // Send one request; valid stays high on return unless the next gap lowers it
    task automatic send_request(logic [1:0] req, logic [KEY_W-1:0] k, logic [POS_W-1:0] idx);
        int      gap;
        t_lookup want;
        gap = send_gaps_on ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid                              <= 1'b1;
        req_type                               <= req;
        {req_key_hi, req_key_mid, req_key_lo}  <= k;
        req_read_index                         <= idx;
        @(posedge clk);
        while (req_stall !== 1'b0) @(posedge clk);
        want = shadow_lookup(req, k, idx);
        lookup_queue.push_back(want);
        sent_cnt++;
        case (req)
            REQ_COUNT: begin
                key_pool.push_back(k);
                if (want.table_full) dropped_keys++;
                else if (want.was_new) new_keys++;
                else repeat_hits++;
            end
            REQ_READ:  reads_done++;
            REQ_CLEAR: clears_done++;
            default: ;
        endcase
    endtask

    // Hold off the response side for a random number of cycles after each response
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_valid === 1'b1 && !rsp_stall)
                stall_left = recv_stalls_on ? $urandom_range(0, 14) : 0;
            else if (stall_left > 0)
                stall_left = stall_left - 1;
            rsp_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk) begin
        t_lookup want;
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall) begin
            results_seen++;
            if (lookup_queue.size() == 0) begin
                note_mismatch("unexpected response", '0, {56'd0, rsp_position});
            end else begin
                want = lookup_queue.pop_front();
                if (rsp_position !== want.position)
                    note_mismatch("position", 64'(want.position), 64'(rsp_position));
                if (rsp_was_new !== want.was_new)
                    note_mismatch("was_new", 64'(want.was_new), 64'(rsp_was_new));
                if (rsp_occurrences !== want.occurrences)
                    note_mismatch("occurrences", 64'(want.occurrences),
                                  64'(rsp_occurrences));
                if (rsp_distinct_keys !== want.distinct_keys)
                    note_mismatch("distinct_keys", 64'(want.distinct_keys),
                                  64'(rsp_distinct_keys));
                if (rsp_table_full !== want.table_full)
                    note_mismatch("table_full", 64'(want.table_full), 64'(rsp_table_full));
                if (rsp_key_hi !== want.key_hi)
                    note_mismatch("key_hi", want.key_hi, rsp_key_hi);
                if (rsp_key_mid !== want.key_mid)
                    note_mismatch("key_mid", want.key_mid, rsp_key_mid);
                if (rsp_key_lo !== want.key_lo)
                    note_mismatch("key_lo", 64'(want.key_lo), 64'(rsp_key_lo));
            end
        end
    end

    task automatic test_empty_table();
        send_request(REQ_READ, '0, 8'd0);
        send_request(REQ_READ, '1, 8'd255);
        send_request(REQ_UNKNOWN, '1, 8'd255);
        send_request(REQ_CLEAR, '0, 8'd0);
    endtask

    task automatic test_key_order();
        send_request(REQ_COUNT, '1, 8'd0);
        send_request(REQ_COUNT, '0, 8'd0);
        // same prefix, keys differ only after an embedded zero byte
        send_request(REQ_COUNT, {32'h4142_0043, 120'd0}, 8'd0);
        send_request(REQ_COUNT, {32'h4142_0044, 120'd0}, 8'd0);
        send_request(REQ_COUNT, {16'h4142, 136'd0}, 8'd0);
        send_request(REQ_COUNT, {128'd0, 24'hFF_FFFF}, 8'd0);
        send_request(REQ_COUNT, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 24'd0}, 8'd0);
        send_request(REQ_COUNT, '1, 8'd0);
        send_request(REQ_COUNT, '0, 8'd0);
        for (int i = 0; i < 8; i++)
            send_request(REQ_READ, '0, POS_W'(i));
        send_request(REQ_READ, '0, 8'd255);
        send_request(REQ_UNKNOWN, '1, 8'd255);
    endtask

    task automatic test_fill_and_drop();
        int n;
        n = 0;
        send_request(REQ_CLEAR, rand_raw(), 8'd0);
        while (shadow_used < TABLE_DEPTH) begin
            if (n % 64 == 0) shuffle_pacing();
            n++;
            send_request(REQ_COUNT, $urandom_range(0, 1) ? rand_name() : rand_raw(), 8'd0);
            if ($urandom_range(0, 7) == 0)
                send_request(REQ_COUNT, key_pool[$urandom_range(0, key_pool.size() - 1)],
                             8'd0);
            if ($urandom_range(0, 7) == 0)
                send_request(REQ_READ, '0, pick_read_index());
        end
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        // full: new keys drop, held keys still count
        for (int i = 0; i < 4; i++) begin
            send_request(REQ_COUNT, rand_raw(), 8'd0);
            send_request(REQ_COUNT, shadow_key[$urandom_range(0, TABLE_DEPTH - 1)], 8'd0);
        end
        send_request(REQ_READ, '0, 8'd255);
        send_request(REQ_READ, '0, 8'd0);
        send_request(REQ_CLEAR, '1, 8'd255);
        send_request(REQ_READ, '0, 8'd0);
    endtask

    task automatic test_mixed_traffic();
        int r;
        for (int n = 0; n < 540; n++) begin
            if (n % 60 == 0) shuffle_pacing();
            r = $urandom_range(0, 99);
            if (r < 58)
                send_request(REQ_COUNT, pick_count_key(), POS_W'($urandom_range(0, 255)));
            else if (r < 92)
                send_request(REQ_READ, rand_raw(), pick_read_index());
            else if (r < 97)
                send_request(REQ_UNKNOWN, rand_raw(), POS_W'($urandom_range(0, 255)));
            else
                send_request(REQ_CLEAR, rand_raw(), POS_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_type       = REQ_COUNT;
        req_key_hi     = '0;
        req_key_mid    = '0;
        req_key_lo     = '0;
        req_read_index = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_key_order();
        test_fill_and_drop();
        test_mixed_traffic();

        req_valid <= 1'b0;
        while (lookup_queue.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d requests: %0d inserts, %0d repeat counts, %0d drops,",
                 sent_cnt, new_keys, repeat_hits, dropped_keys);
        $display("  %0d reads, %0d clears; checked %0d responses, %0d mismatches",
                 reads_done, clears_done, results_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && lookup_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
